### hw/rtl/char_table_string_codec_macros.svh
// ----------------------------------------------------------------------------
// char_table_string_codec_macros.svh
// Assertion macros for the character table string codec.
// ----------------------------------------------------------------------------
`ifndef CHAR_TABLE_STRING_CODEC_MACROS_SVH
`define CHAR_TABLE_STRING_CODEC_MACROS_SVH

`ifndef SYNTH
`define CSTC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSTC_NEVER(lbl, clk, rst, cond, msg) \
   `CSTC_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define CSTC_ASSERT(lbl, clk, rst, prop, msg)
`define CSTC_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

### hw/rtl/cstc_pkg.sv
// ----------------------------------------------------------------------------
// cstc_pkg
// Shared widths, codes and helpers of the character table string codec.
// ----------------------------------------------------------------------------
package cstc_pkg;

   localparam int TABLE_DEPTH_DEF = 8192;

   localparam int MODE_W = 2;
   localparam int IDX_W  = 13;
   localparam int CHAR_W = 16;
   localparam int BYTE_W = 8;
   localparam int SIZE_W = 14;

   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DECODE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TERM   = 2'd3;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'd224;
   localparam logic [BYTE_W-1:0] LO_OFFSET = 8'd33;
   localparam logic [15:0]       IDX_BIAS  = 16'hDE41;

   // x / 255 for small x, by reciprocal with correction
   function automatic logic [BYTE_W-1:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return sum[15:8];
   endfunction

endpackage

### hw/rtl/cstc_ram.sv
// ----------------------------------------------------------------------------
// cstc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cstc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/char_table_string_codec.sv
// ----------------------------------------------------------------------------
// char_table_string_codec
// Character table string codec: load, decode, encode and terminate beats.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   req_*                      start & !busy
//  response  rsp_*                      rsp_valid strobe, one cycle per beat
//  config    csr_wr_en, csr_wr_data     csr_wr_en
//
//  Load: written at accept, stays idle. Terminate: result the next cycle. Lead byte: stored at accept.
//  Decode: result registered out of ST_DEC_RD (one table RAM read).
//  Encode: the linear scan in ST_SEARCH does one RAM read per cycle; a hit at
//  entry m gives one byte, or two bytes through ST_ENC_HI and ST_ENC_LO, after
//  ST_ENC_DIV; a miss over s entries gives byte 0.
//  Reset is synchronous; the table RAM is not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
`include "char_table_string_codec_macros.svh"

module char_table_string_codec #(
   parameter int TABLE_DEPTH = cstc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cstc_pkg::MODE_W-1:0]   req_mode,
   input  logic [cstc_pkg::IDX_W-1:0]    req_table_index,
   input  logic [cstc_pkg::CHAR_W-1:0]   req_wide_char,
   input  logic [cstc_pkg::BYTE_W-1:0]   req_code_byte,
   input  logic                          csr_wr_en,
   input  logic [cstc_pkg::SIZE_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   output logic                          rsp_result_kind,
   output logic [cstc_pkg::CHAR_W-1:0]   rsp_decoded_char,
   output logic [cstc_pkg::BYTE_W-1:0]   rsp_byte_out,
   output logic                          rsp_index_error,
   output logic                          rsp_last
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [cstc_pkg::SIZE_W-1:0] DepthSz = cstc_pkg::SIZE_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEC_RD,
      ST_SEARCH,
      ST_ENC_DIV,
      ST_ENC_HI,
      ST_ENC_LO
   } state_type;

   state_type                      state_ff, state_in;
   logic                           lead_pend_ff, lead_pend_in;
   logic [cstc_pkg::BYTE_W-1:0]    lead_val_ff, lead_val_in;
   logic [cstc_pkg::SIZE_W-1:0]    table_size_ff, table_size_in;
   logic [cstc_pkg::CHAR_W-1:0]    wc_ff, wc_in;
   logic [CW-1:0]                  cmp_ff, cmp_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic [cstc_pkg::BYTE_W-1:0]    p0_ff, p0_in;
   logic                           dec_err_ff, dec_err_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [cstc_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [cstc_pkg::BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                           rsp_err_ff, rsp_err_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic [cstc_pkg::SIZE_W-1:0]    eff_size;
   logic [15:0]                    lead_prod;
   logic [15:0]                    pair_idx;
   logic [cstc_pkg::SIZE_W-1:0]    dec_idx;
   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [cstc_pkg::CHAR_W-1:0]    ram_rd_data;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign eff_size = (table_size_ff > DepthSz) ? DepthSz : table_size_ff;

   assign lead_prod = {lead_val_ff, 8'h00} - {8'h00, lead_val_ff};
   assign pair_idx  = lead_prod + {8'h00, req_code_byte} - cstc_pkg::IDX_BIAS;
   assign dec_idx   = lead_pend_ff ? pair_idx[cstc_pkg::SIZE_W-1:0]
                                   : cstc_pkg::SIZE_W'(req_code_byte);

   assign ram_wr_en = accept && (req_mode == cstc_pkg::MODE_LOAD)
                      && (cstc_pkg::SIZE_W'(req_table_index) < DepthSz);

   always_comb begin
      if (state_ff == ST_SEARCH) begin
         ram_rd_addr = AW'(cmp_ff + CW'(1));
      end else if (req_mode == cstc_pkg::MODE_DECODE) begin
         ram_rd_addr = AW'(dec_idx);
      end else begin
         ram_rd_addr = '0;
      end
   end

   cstc_ram #(
      .WIDTH (cstc_pkg::CHAR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_table_index)),
      .wr_data (req_wide_char),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      lead_pend_in  = lead_pend_ff;
      lead_val_in   = lead_val_ff;
      table_size_in = csr_wr_en ? csr_wr_data : table_size_ff;
      wc_in         = wc_ff;
      cmp_in        = cmp_ff;
      pos_in        = pos_ff;
      p0_in         = p0_ff;
      dec_err_in    = dec_err_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  cstc_pkg::MODE_DECODE: begin
                     if (lead_pend_ff || (req_code_byte < cstc_pkg::LEAD_MIN)) begin
                        lead_pend_in = 1'b0;
                        dec_err_in   = !(dec_idx < eff_size);
                        state_in     = ST_DEC_RD;
                     end else begin
                        lead_pend_in = 1'b1;
                        lead_val_in  = req_code_byte;
                     end
                  end
                  cstc_pkg::MODE_ENCODE: begin
                     wc_in    = req_wide_char;
                     cmp_in   = '0;
                     state_in = ST_SEARCH;
                  end
                  cstc_pkg::MODE_TERM: begin
                     lead_pend_in = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = cstc_pkg::KIND_BYTE;
                     rsp_char_in  = '0;
                     rsp_byte_in  = '0;
                     rsp_err_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DEC_RD: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = cstc_pkg::KIND_CHAR;
            rsp_char_in  = dec_err_ff ? '0 : ram_rd_data;
            rsp_byte_in  = '0;
            rsp_err_in   = dec_err_ff;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SEARCH: begin
            if (cstc_pkg::SIZE_W'(cmp_ff) >= eff_size) begin
               pos_in   = '0;
               state_in = ST_ENC_DIV;
            end else if (ram_rd_data == wc_ff) begin
               pos_in   = AW'(cmp_ff);
               state_in = ST_ENC_DIV;
            end else begin
               cmp_in = cmp_ff + CW'(1);
            end
         end
         ST_ENC_DIV: begin
            if (16'(pos_ff) < 16'(cstc_pkg::LEAD_MIN)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cstc_pkg::KIND_BYTE;
               rsp_char_in  = '0;
               rsp_byte_in  = pos_ff[cstc_pkg::BYTE_W-1:0];
               rsp_err_in   = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               p0_in    = cstc_pkg::div255(16'(pos_ff) - 16'(cstc_pkg::LEAD_MIN));
               state_in = ST_ENC_HI;
            end
         end
         ST_ENC_HI: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = cstc_pkg::KIND_BYTE;
            rsp_char_in  = '0;
            rsp_byte_in  = p0_ff + cstc_pkg::LEAD_MIN;
            rsp_err_in   = 1'b0;
            rsp_last_in  = 1'b0;
            state_in     = ST_ENC_LO;
         end
         ST_ENC_LO: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = cstc_pkg::KIND_BYTE;
            rsp_char_in  = '0;
            rsp_byte_in  = pos_ff[cstc_pkg::BYTE_W-1:0] + cstc_pkg::LO_OFFSET + p0_ff;
            rsp_err_in   = 1'b0;
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lead_pend_ff  <= 1'b0;
         lead_val_ff   <= '0;
         table_size_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lead_pend_ff  <= lead_pend_in;
         lead_val_ff   <= lead_val_in;
         table_size_ff <= table_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      wc_ff       <= wc_in;
      cmp_ff      <= cmp_in;
      pos_ff      <= pos_in;
      p0_ff       <= p0_in;
      dec_err_ff  <= dec_err_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_decoded_char = rsp_char_ff;
   assign rsp_byte_out     = rsp_byte_ff;
   assign rsp_index_error  = rsp_err_ff;
   assign rsp_last         = rsp_last_ff;

   `CSTC_ASSERT(a_pair_follows, clock, reset, rsp_valid && !rsp_last |=> rsp_valid && rsp_last, "lead byte without its second byte")
   `CSTC_ASSERT(a_err_only_decode, clock, reset, rsp_valid && rsp_index_error |-> rsp_result_kind == cstc_pkg::KIND_CHAR && rsp_decoded_char == '0, "index error on a non-decode beat")
   `CSTC_ASSERT(a_encode_holds, clock, reset, start && !busy && req_mode == cstc_pkg::MODE_ENCODE |=> busy && !rsp_valid, "encode did not start its scan")

endmodule
